>>> rtl/wph_pkg.sv
// Package: shared widths, sizes, register indexes and reset values for the presence detector.
`default_nettype none
package wph_pkg;

	localparam int PEOPLE     = 8;
	localparam int HIST_DEPTH = 32;
	localparam int SLOT_W     = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HIST_DEPTH + 1);
	localparam int MASK_W     = 8;
	localparam int STRIDE_W   = 8;
	localparam int THR_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	typedef logic [MASK_W-1:0] mask_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_STRIDE    = 2'd0,
		REG_ENTER_THRESHOLD = 2'd1,
		REG_LEAVE_THRESHOLD = 2'd2
	} cfg_reg_t;

	localparam logic [STRIDE_W-1:0] FRAME_STRIDE_RST    = 8'd3;
	localparam logic [THR_W-1:0]    ENTER_THRESHOLD_RST = 9'd28;
	localparam logic [THR_W-1:0]    LEAVE_THRESHOLD_RST = 9'd4;

endpackage
`default_nettype wire

>>> rtl/windowed_presence_hysteresis_top.sv
// Top level: sliding-window presence detector with enter/leave hysteresis per person.
// A result passes the stage 1 registers (history RAM read), then the output register (count update).
// Accepts one frame per cycle while the output is not stalled.
// A stalled output holds one result in the output register; input stalls only behind it.
// Reset (async, active low) clears counts, present flags, stride phase, write slot and the
// per-slot history valid bits, and loads the config defaults; no clearing pass, ready at once.
`default_nettype none
module windowed_presence_hysteresis_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// config write port
	input  wire logic                            cfg_we,
	input  wire logic [wph_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [wph_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// frame input
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [wph_pkg::MASK_W-1:0]      recognized_mask,
	// result output
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic                                 processed,
	output logic      [wph_pkg::MASK_W-1:0]      present_mask,
	output logic      [wph_pkg::MASK_W-1:0]      arrived_mask,
	output logic      [wph_pkg::MASK_W-1:0]      departed_mask
);

	// ---------------- configuration registers ----------------
	logic [wph_pkg::STRIDE_W-1:0] frame_stride_q;
	logic [wph_pkg::THR_W-1:0]    enter_thr_q;
	logic [wph_pkg::THR_W-1:0]    leave_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_stride_q <= wph_pkg::FRAME_STRIDE_RST;
			enter_thr_q    <= wph_pkg::ENTER_THRESHOLD_RST;
			leave_thr_q    <= wph_pkg::LEAVE_THRESHOLD_RST;
		end else if (cfg_we) begin
			case (wph_pkg::cfg_reg_t'(cfg_idx))
				wph_pkg::REG_FRAME_STRIDE:    frame_stride_q <= cfg_wdata[wph_pkg::STRIDE_W-1:0];
				wph_pkg::REG_ENTER_THRESHOLD: enter_thr_q    <= cfg_wdata[wph_pkg::THR_W-1:0];
				wph_pkg::REG_LEAVE_THRESHOLD: leave_thr_q    <= cfg_wdata[wph_pkg::THR_W-1:0];
				default: ;  // unmapped index: write dropped
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	logic in_xfer;
	logic s1_go;
	logic s1_vld_q;
	logic out_vld_q;

	assign s1_go    = s1_vld_q && (!out_vld_q || out_ready);
	assign in_ready = !s1_vld_q || s1_go;
	assign in_xfer  = in_valid && in_ready;

	// ---------------- stage 0: stride sampling, slot allocation ----------------
	logic [wph_pkg::STRIDE_W-1:0] phase_q;
	logic [wph_pkg::STRIDE_W-1:0] stride_eff;
	logic [wph_pkg::STRIDE_W:0]   phase_inc;
	logic [wph_pkg::STRIDE_W-1:0] phase_nxt;
	logic                         take;
	wph_pkg::slot_t               slot_q;
	logic [wph_pkg::HIST_DEPTH-1:0] hist_vld_q;  // slot written since reset

	// stride of zero behaves as one; a phase past a lowered stride wraps next frame
	assign stride_eff = (frame_stride_q == '0) ? wph_pkg::STRIDE_W'(1) : frame_stride_q;
	assign phase_inc  = {1'b0, phase_q} + (wph_pkg::STRIDE_W+1)'(1);
	assign phase_nxt  = (phase_inc >= {1'b0, stride_eff}) ? '0
	                                                      : phase_inc[wph_pkg::STRIDE_W-1:0];
	assign take       = (phase_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			slot_q  <= '0;
		end else if (in_xfer) begin
			phase_q <= phase_nxt;
			if (take) begin
				slot_q <= slot_q + wph_pkg::SLOT_W'(1);  // depth is a power of two: wraps
			end
		end
	end

	// ---------------- stage 1 registers ----------------
	logic           take_s1;
	wph_pkg::mask_t mask_s1;
	wph_pkg::slot_t slot_s1;
	logic           old_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (in_xfer) begin
			s1_vld_q <= 1'b1;
		end else if (s1_go) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			take_s1    <= take;
			mask_s1    <= recognized_mask;
			slot_s1    <= slot_q;
			old_vld_s1 <= hist_vld_q[slot_q];
		end
	end

	// ---------------- history RAM ----------------
	// Consecutive processed frames use consecutive slots, so the read in stage 0
	// never targets the slot being written in stage 1: no forwarding needed.
	logic           hist_we;
	wph_pkg::mask_t hist_rd;
	wph_pkg::mask_t old_mask;

	assign hist_we = s1_go && take_s1;

	wph_ram #(
		.WIDTH (wph_pkg::MASK_W),
		.DEPTH (wph_pkg::HIST_DEPTH)
	) u_hist (
		.clk     (clk),
		.we      (hist_we),
		.wr_addr (slot_s1),
		.wr_data (mask_s1),
		.re      (in_xfer && take),
		.rd_addr (slot_q),
		.rd_data (hist_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
		end else if (hist_we) begin
			hist_vld_q[slot_s1] <= 1'b1;
		end
	end

	// unwritten slot reads as the reset value (no hits)
	assign old_mask = old_vld_s1 ? hist_rd : '0;

	// ---------------- stage 1: count update and hysteresis ----------------
	wph_pkg::cnt_t                  cnt_q   [wph_pkg::PEOPLE];
	wph_pkg::cnt_t                  cnt_nxt [wph_pkg::PEOPLE];
	logic [wph_pkg::PEOPLE-1:0]     present_q;
	logic [wph_pkg::PEOPLE-1:0]     present_nxt;
	logic [wph_pkg::PEOPLE-1:0]     arrived_nxt;
	logic [wph_pkg::PEOPLE-1:0]     departed_nxt;

	always_comb begin
		logic [wph_pkg::THR_W-1:0] c_ext;
		logic                      p;
		for (int i = 0; i < wph_pkg::PEOPLE; i++) begin
			cnt_nxt[i] = cnt_q[i] - wph_pkg::CNT_W'(old_mask[i]) + wph_pkg::CNT_W'(mask_s1[i]);
			c_ext      = {{(wph_pkg::THR_W-wph_pkg::CNT_W){1'b0}}, cnt_nxt[i]};
			p          = present_q[i];
			arrived_nxt[i]  = 1'b0;
			departed_nxt[i] = 1'b0;
			// enter is checked first; a count inside both bands makes an absent person enter and leave at once
			if (c_ext >= enter_thr_q && !p) begin
				p               = 1'b1;
				arrived_nxt[i]  = 1'b1;
			end
			if (c_ext <= leave_thr_q && p) begin
				p               = 1'b0;
				departed_nxt[i] = 1'b1;
			end
			present_nxt[i] = p;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			for (int i = 0; i < wph_pkg::PEOPLE; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (hist_we) begin
			present_q <= present_nxt;
			for (int i = 0; i < wph_pkg::PEOPLE; i++) begin
				cnt_q[i] <= cnt_nxt[i];
			end
		end
	end

	// ---------------- output register ----------------
	logic           processed_q;
	wph_pkg::mask_t present_out_q;
	wph_pkg::mask_t arrived_out_q;
	wph_pkg::mask_t departed_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_go) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// skipped frame reports current flags with empty change masks
	always_ff @(posedge clk) begin
		if (s1_go) begin
			processed_q    <= take_s1;
			present_out_q  <= take_s1 ? present_nxt : present_q;
			arrived_out_q  <= take_s1 ? arrived_nxt : '0;
			departed_out_q <= take_s1 ? departed_nxt : '0;
		end
	end

	assign out_valid     = out_vld_q;
	assign processed     = processed_q;
	assign present_mask  = present_out_q;
	assign arrived_mask  = arrived_out_q;
	assign departed_mask = departed_out_q;

endmodule
`default_nettype wire

>>> rtl/wph_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none
module wph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/wph_checker.sv
// Checker: port-level properties of the presence detector, bound to the top level.
`default_nettype none
module wph_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       processed,
	input wire logic [wph_pkg::MASK_W-1:0] present_mask,
	input wire logic [wph_pkg::MASK_W-1:0] arrived_mask,
	input wire logic [wph_pkg::MASK_W-1:0] departed_mask
);

	// stalled transfer keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(processed) &&
		$stable(present_mask) && $stable(arrived_mask) && $stable(departed_mask))
		else $error("output transfer dropped or changed while stalled");

	a_skip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !processed |-> arrived_mask == '0 && departed_mask == '0)
		else $error("skipped frame reports arrivals or departures");

	// arrival without departure leaves the person present
	a_arrive_present: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (arrived_mask & ~departed_mask & ~present_mask) == '0)
		else $error("arrived person not present");

	a_depart_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (departed_mask & present_mask) == '0)
		else $error("departed person still present");

endmodule

bind windowed_presence_hysteresis_top wph_checker u_wph_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.processed     (processed),
	.present_mask  (present_mask),
	.arrived_mask  (arrived_mask),
	.departed_mask (departed_mask)
);
`default_nettype wire

>>> tb/sv/windowed_presence_hysteresis_top_tb.sv
// Self-checking testbench for the windowed presence detector: driver, monitor and predictor.
`timescale 1ns / 1ps
module windowed_presence_hysteresis_top_tb;

	typedef struct packed {
		logic           processed;
		wph_pkg::mask_t present;
		wph_pkg::mask_t arrived;
		wph_pkg::mask_t departed;
	} presence_result_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [wph_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [wph_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	wph_pkg::mask_t                 recognized_mask = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           processed;
	wph_pkg::mask_t                 present_mask;
	wph_pkg::mask_t                 arrived_mask;
	wph_pkg::mask_t                 departed_mask;

	windowed_presence_hysteresis_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.recognized_mask (recognized_mask),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.processed       (processed),
		.present_mask    (present_mask),
		.arrived_mask    (arrived_mask),
		.departed_mask   (departed_mask)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Frames waiting to be offered, and predicted results waiting for the output.
	wph_pkg::mask_t   pending_frames[$];
	presence_result_t expected_results[$];

	// Idle rates in percent for the sending and receiving side.
	int sender_idle_pct = 16;
	int receiver_idle_pct = 56;
	int errors = 0;

	// Shadow of the config registers, starting from their reset values.
	int stride_cfg = wph_pkg::FRAME_STRIDE_RST;
	int enter_cfg  = wph_pkg::ENTER_THRESHOLD_RST;
	int leave_cfg  = wph_pkg::LEAVE_THRESHOLD_RST;

	// Predictor state: ring of past masks, next slot, stride phase, per-person
	// hit counts over the window and the present flags.
	wph_pkg::mask_t window_hist[wph_pkg::HIST_DEPTH];
	wph_pkg::slot_t write_slot = '0;
	logic [7:0]     stride_phase = '0;
	int             hit_count[wph_pkg::PEOPLE];
	wph_pkg::mask_t present_now = '0;

	// Which people are currently "in view"; drives the well-formed part of the
	// random stimulus so that counts actually climb past the thresholds.
	wph_pkg::mask_t in_view = '0;

	initial begin
		foreach (window_hist[k])
			window_hist[k] = '0;
		foreach (hit_count[k])
			hit_count[k] = 0;
	end

	// Works out the result of one frame and advances the predictor state.
	function automatic presence_result_t predict_presence(input wph_pkg::mask_t frame);
		presence_result_t r;
		int               span;
		wph_pkg::mask_t   oldest;
		r = '0;
		span = (stride_cfg == 0) ? 1 : stride_cfg;
		r.processed = (stride_phase == 0);
		// a phase at or above a freshly lowered stride wraps here as well
		if (int'(stride_phase) + 1 >= span)
			stride_phase = '0;
		else
			stride_phase = stride_phase + 8'd1;
		if (r.processed) begin
			oldest = window_hist[write_slot];
			for (int i = 0; i < wph_pkg::PEOPLE; i++)
				hit_count[i] = hit_count[i] - int'(oldest[i]) + int'(frame[i]);
			window_hist[write_slot] = frame;
			write_slot = write_slot + 1'b1;
			// enter is checked before leave, so both may fire in one frame
			for (int i = 0; i < wph_pkg::PEOPLE; i++) begin
				if (hit_count[i] >= enter_cfg && !present_now[i]) begin
					present_now[i] = 1'b1;
					r.arrived[i] = 1'b1;
				end
				if (hit_count[i] <= leave_cfg && present_now[i]) begin
					present_now[i] = 1'b0;
					r.departed[i] = 1'b1;
				end
			end
		end
		r.present = present_now;
		return r;
	endfunction

	// Driver: predicts on each input transfer, then offers the next frame
	// unless it idles. Valid only drops after a transfer.
	always @(posedge clk) begin
		presence_result_t pred;
		if (!arst_n) begin
			in_valid <= 1'b0;
			recognized_mask <= '0;
		end else begin
			if (in_valid && in_ready) begin
				pred = predict_presence(recognized_mask);
				expected_results = {expected_results, pred};
			end
			if (!in_valid || in_ready) begin
				if (pending_frames.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
					in_valid <= 1'b1;
					recognized_mask <= pending_frames.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: random backpressure, and each output transfer checked against
	// the oldest prediction.
	always @(posedge clk) begin
		presence_result_t got;
		presence_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
			if (out_valid && out_ready) begin
				got = {processed, present_mask, arrived_mask, departed_mask};
				if (expected_results.size() == 0) begin
					errors++;
					if (errors < 50)
						$display("%0t: unexpected result p=%0b pres=%02h arr=%02h dep=%02h",
							$time, got.processed, got.present, got.arrived, got.departed);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						errors++;
						if (errors < 50)
							$display({"%0t: mismatch expected p=%0b pres=%02h arr=%02h dep=%02h",
								" actual p=%0b pres=%02h arr=%02h dep=%02h"}, $time,
								want.processed, want.present, want.arrived, want.departed,
								got.processed, got.present, got.arrived, got.departed);
					end
				end
			end
		end
	end

	// Register write; only called with the block idle, so the shadow can
	// change right away.
	task automatic write_reg(input wph_pkg::cfg_reg_t idx, input int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= value[wph_pkg::CFG_DATA_W-1:0];
		case (idx)
			wph_pkg::REG_FRAME_STRIDE:    stride_cfg = value & 8'hFF;
			wph_pkg::REG_ENTER_THRESHOLD: enter_cfg = value & 9'h1FF;
			wph_pkg::REG_LEAVE_THRESHOLD: leave_cfg = value & 9'h1FF;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input int stride, input int enter, input int leave);
		write_reg(wph_pkg::REG_FRAME_STRIDE, stride);
		write_reg(wph_pkg::REG_ENTER_THRESHOLD, enter);
		write_reg(wph_pkg::REG_LEAVE_THRESHOLD, leave);
	endtask

	// Holds off until every frame has been sent and every result has come
	// back, then gives the pipeline some slack.
	task automatic wait_idle();
		while (pending_frames.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly people that stay in or out of view for a while, with the odd
	// missed or spurious detection; one frame in ten is pure noise.
	task automatic queue_frames(input int count);
		wph_pkg::mask_t m;
		for (int n = 0; n < count; n++) begin
			for (int b = 0; b < wph_pkg::MASK_W; b++)
				if ($urandom_range(39) == 0)
					in_view[b] = ~in_view[b];
			if ($urandom_range(9) == 0) begin
				m = wph_pkg::mask_t'($urandom);
			end else begin
				m = in_view;
				if ($urandom_range(9) == 0)
					m[$urandom_range(wph_pkg::MASK_W - 1)] ^= 1'b1;
			end
			pending_frames = {pending_frames, m};
		end
	endtask

	initial begin
		int k;
		int leave;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset config (stride 3): extremes of the mask and skipped frames.
		pending_frames = {8'h00, 8'hFF, 8'hAA, 8'h55, 8'hFF, 8'h01, 8'h80};
		wait_idle();
		// Zero stride acts as one; enter below leave makes people arrive and
		// depart in the same frame.
		set_config(0, 1, 2);
		pending_frames = {8'hFF, 8'h0F, 8'h00};
		wait_idle();
		// Enter beyond the window is never reached; widest stride skips a lot.
		set_config(255, 256, 0);
		pending_frames = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
		wait_idle();
		// Phase left above a lowered stride wraps on the next frame.
		write_reg(wph_pkg::REG_FRAME_STRIDE, 2);
		pending_frames = {8'h3C, 8'h3C, 8'h3C, 8'h3C};
		wait_idle();
		// Everyone enters at zero and leaves again at the top threshold.
		set_config(1, 0, 256);
		pending_frames = {8'hC3, 8'h00};
		wait_idle();

		// Random part: three idling patterns, three settings each. Every
		// setting change waits for all results, which also pauses the sender.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 16;
					receiver_idle_pct = 56;
				end
				1: begin
					sender_idle_pct = 56;
					receiver_idle_pct = 16;
				end
				default: begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < 3; s++) begin
				k = ph * 3 + s;
				wait_idle();
				if (k == 0) begin
					set_config(1, wph_pkg::HIST_DEPTH, 0);
				end else if (k == 4) begin
					set_config(2, 256, 256);
				end else if (k == 7) begin
					set_config(0, wph_pkg::HIST_DEPTH + 1, 3);
				end else begin
					leave = $urandom_range(12);
					set_config(($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(1, 4),
						($urandom_range(4) == 0) ? $urandom_range(256)
							: $urandom_range(leave + 1, wph_pkg::HIST_DEPTH),
						leave);
				end
				queue_frames(200);
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

>>> filelist.f
rtl/wph_pkg.sv
rtl/wph_ram.sv
rtl/windowed_presence_hysteresis_top.sv
rtl/wph_checker.sv
tb/sv/windowed_presence_hysteresis_top_tb.sv
